/* src/lfsf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsf_pkg
// Shared types and constants of the largest free square finder.
// ----------------------------------------------------------------------------
package lfsf_pkg;

	localparam int MAX_WIDTH_DEFAULT = 1024;
	localparam int MAX_ROWS_DEFAULT  = 4096;

	// fixed field widths
	localparam int SIDE_W    = 11;
	localparam int OUT_COL_W = 10;
	localparam int OUT_ROW_W = 12;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 40;

	localparam logic [SIDE_W-1:0] SIDE_MAX = {SIDE_W{1'b1}};

	// register reset values before clamping
	localparam int ROW_WIDTH_RESET = 1024;
	localparam int ROW_COUNT_RESET = 4096;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b1;

	// where the current cell sits in the grid
	typedef struct packed {
		logic bottom;     // bottom row of the grid
		logic rightmost;  // rightmost column
		logic row_end;    // column 0
		logic last_cell;  // row 0, column 0
	} lfsf_pos_flags_t;

endpackage

/* src/lfsf_line_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsf_line_buf
// Line buffer holding the scores of the row below, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module lfsf_line_buf #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 11
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* src/lfsf_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsf_scan
// Grid geometry registers and the column/row scan position of the next cell.
// ----------------------------------------------------------------------------
module lfsf_scan #(
	parameter int MAX_WIDTH = lfsf_pkg::MAX_WIDTH_DEFAULT,
	parameter int MAX_ROWS  = lfsf_pkg::MAX_ROWS_DEFAULT,
	parameter int COL_W     = 10,
	parameter int ROW_W     = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lfsf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lfsf_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                            advance,
	output logic [COL_W-1:0]                col,
	output logic [ROW_W-1:0]                row,
	output lfsf_pkg::lfsf_pos_flags_t       flags
);

	import lfsf_pkg::*;

	localparam int RST_W = (ROW_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : ROW_WIDTH_RESET;
	localparam int RST_R = (ROW_COUNT_RESET > MAX_ROWS) ? MAX_ROWS : ROW_COUNT_RESET;
	localparam logic [COL_W-1:0] RESET_LAST_COL = COL_W'(RST_W - 1);
	localparam logic [ROW_W-1:0] RESET_LAST_ROW = ROW_W'(RST_R - 1);
	localparam logic [COL_W-1:0] CLAMP_LAST_COL = COL_W'(MAX_WIDTH - 1);
	localparam logic [ROW_W-1:0] CLAMP_LAST_ROW = ROW_W'(MAX_ROWS - 1);

	logic [COL_W-1:0] last_col_q, col_q, new_last_col;
	logic [ROW_W-1:0] last_row_q, row_q, new_last_row;
	logic [10:0]      wval;
	logic [12:0]      rval;

	assign wval = cfg_wdata[10:0];
	assign rval = cfg_wdata[12:0];

	// clamp the written value into 1..MAX and keep it as the last index
	always_comb begin
		new_last_col = last_col_q;
		new_last_row = last_row_q;
		if (cfg_index == REG_ROW_WIDTH) begin
			if (wval == '0) begin
				new_last_col = '0;
			end else if (int'(wval) > MAX_WIDTH) begin
				new_last_col = CLAMP_LAST_COL;
			end else begin
				new_last_col = COL_W'(wval - 11'd1);
			end
		end else begin
			if (rval == '0) begin
				new_last_row = '0;
			end else if (int'(rval) > MAX_ROWS) begin
				new_last_row = CLAMP_LAST_ROW;
			end else begin
				new_last_row = ROW_W'(rval - 13'd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= RESET_LAST_COL;
			last_row_q <= RESET_LAST_ROW;
			col_q      <= RESET_LAST_COL;
			row_q      <= RESET_LAST_ROW;
		end else if (cfg_we) begin
			// restart the scan with the new geometry
			last_col_q <= new_last_col;
			last_row_q <= new_last_row;
			col_q      <= new_last_col;
			row_q      <= new_last_row;
		end else if (advance) begin
			if (col_q != '0) begin
				col_q <= col_q - 1'b1;
			end else begin
				col_q <= last_col_q;
				row_q <= (row_q != '0) ? row_q - 1'b1 : last_row_q;
			end
		end
	end

	assign col             = col_q;
	assign row             = row_q;
	assign flags.bottom    = (row_q == last_row_q);
	assign flags.rightmost = (col_q == last_col_q);
	assign flags.row_end   = (col_q == '0);
	assign flags.last_cell = (col_q == '0) && (row_q == '0);

endmodule

/* src/largest_free_square_finder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_free_square_finder_unit
// Streams grid cells, scores each one against the row below and reports the
// largest free square after the last cell.
// ----------------------------------------------------------------------------
// Cells enter bottom row first, right to left, one per clock with no gaps
// needed; the only thing that sets this rate is the line buffer, which gives
// one read and one write per cycle. Each cell is scored in the cycle after
// it is accepted, and the result beat (top-left corner and side of the
// largest square, the topmost-leftmost on ties) is loaded into the output
// register when the cell at row 0, column 0 leaves s1. Input is held off
// only while a finished result still waits and the last cell of the next
// grid is ready to complete. A write to row_width or row_count restarts the
// scan; the line buffer needs no clearing after reset.
module largest_free_square_finder_unit #(
	parameter int MAX_WIDTH = lfsf_pkg::MAX_WIDTH_DEFAULT,
	parameter int MAX_ROWS  = lfsf_pkg::MAX_ROWS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lfsf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lfsf_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [lfsf_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [0] cell_free
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [9:0] corner_column, [21:10] corner_row, [32:22] square_side
	output logic [lfsf_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

	import lfsf_pkg::*;

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic               accept, s1_fire, s1_go;
	logic [COL_W-1:0]   scan_col;
	logic [ROW_W-1:0]   scan_row;
	lfsf_pos_flags_t    scan_flags;

	logic               valid_s1, free_s1, fwd_s1;
	logic [COL_W-1:0]   col_s1;
	logic [ROW_W-1:0]   row_s1;
	lfsf_pos_flags_t    flags_s1;

	logic [SIDE_W-1:0]  rd_data, wr_score_q, right_q, below_right_q;
	logic [SIDE_W-1:0]  below, min3, score;
	logic               take;

	logic [SIDE_W-1:0]  best_side_q;
	logic [COL_W-1:0]   best_col_q;
	logic [ROW_W-1:0]   best_row_q;
	logic [SIDE_W-1:0]  nb_side;
	logic [COL_W-1:0]   nb_col;
	logic [ROW_W-1:0]   nb_row;

	logic               out_valid_q;
	logic [OUT_COL_W-1:0] out_col_q;
	logic [OUT_ROW_W-1:0] out_row_q;
	logic [SIDE_W-1:0]    out_side_q;

	// hold the last cell while an unread result still sits in the output
	assign s1_go         = !(flags_s1.last_cell && out_valid_q && !m_axis_tready);
	assign s1_fire       = valid_s1 && s1_go;
	assign s_axis_tready = !valid_s1 || s1_go;
	assign accept        = s_axis_tvalid && s_axis_tready;

	lfsf_scan #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_ROWS  (MAX_ROWS),
		.COL_W     (COL_W),
		.ROW_W     (ROW_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.advance   (accept),
		.col       (scan_col),
		.row       (scan_row),
		.flags     (scan_flags)
	);

	lfsf_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (COL_W),
		.DW    (SIDE_W)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (scan_col),
		.rd_data (rd_data),
		.wr_en   (s1_fire),
		.wr_addr (col_s1),
		.wr_data (score)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			free_s1  <= s_axis_tdata[0];
			col_s1   <= scan_col;
			row_s1   <= scan_row;
			flags_s1 <= scan_flags;
			// the entry is being written this very edge: take the score instead
			fwd_s1   <= s1_fire && (scan_col == col_s1);
		end
		if (s1_fire) begin
			wr_score_q <= score;
		end
	end

	// score of the cell in s1
	always_comb begin
		if (flags_s1.bottom) begin
			below = '0;
		end else begin
			below = fwd_s1 ? wr_score_q : rd_data;
		end
		min3 = below;
		if (right_q < min3) begin
			min3 = right_q;
		end
		if (below_right_q < min3) begin
			min3 = below_right_q;
		end
		priority if (!free_s1) begin
			score = '0;
		end else if (flags_s1.bottom || flags_s1.rightmost) begin
			score = SIDE_W'(1);
		end else begin
			score = (min3 == SIDE_MAX) ? SIDE_MAX : min3 + 1'b1;
		end
		take    = (score != '0) && (score >= best_side_q);
		nb_side = take ? score  : best_side_q;
		nb_col  = take ? col_s1 : best_col_q;
		nb_row  = take ? row_s1 : best_row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q       <= '0;
			below_right_q <= '0;
			best_side_q   <= '0;
			best_col_q    <= '0;
			best_row_q    <= '0;
		end else if (cfg_we) begin
			right_q       <= '0;
			below_right_q <= '0;
			best_side_q   <= '0;
			best_col_q    <= '0;
			best_row_q    <= '0;
		end else if (s1_fire) begin
			if (flags_s1.row_end) begin
				right_q       <= '0;
				below_right_q <= '0;
			end else begin
				right_q       <= score;
				below_right_q <= below;
			end
			if (flags_s1.last_cell) begin
				best_side_q <= '0;
				best_col_q  <= '0;
				best_row_q  <= '0;
			end else begin
				best_side_q <= nb_side;
				best_col_q  <= nb_col;
				best_row_q  <= nb_row;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && flags_s1.last_cell) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && flags_s1.last_cell) begin
			out_col_q  <= OUT_COL_W'(nb_col);
			out_row_q  <= OUT_ROW_W'(nb_row);
			out_side_q <= nb_side;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_side_q, out_row_q, out_col_q};

endmodule

/* src/lfsf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsf_checker
// Port-level checks of the largest free square finder, bound to the top.
// ----------------------------------------------------------------------------
module lfsf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [lfsf_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	// a result beat may only rise after an accepted cell
	a_result_follows_cell: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result beat without a cell accepted two cycles earlier");

	// no free square means both corner fields are zero
	a_empty_corner_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[32:22] == 11'd0) |-> (m_axis_tdata[21:0] == 22'd0))
		else $error("empty result with a non-zero corner");

	// hold a stalled result beat
	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");

	a_out_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

endmodule

bind largest_free_square_finder_unit lfsf_checker u_lfsf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of largest_free_square_finder_unit. Grid cells are streamed in
// under random idling on both sides. An in-bench scorer follows the maximal
// square recurrence cell by cell and queues the corner and side that each
// completed grid must report, and every result beat is compared with it.
// ----------------------------------------------------------------------------
module tb;
	import lfsf_pkg::*;

	localparam int MAX_W       = MAX_WIDTH_DEFAULT;
	localparam int MAX_H       = MAX_ROWS_DEFAULT;
	localparam int STALL_LIMIT = 2000;

	// which registers a configuration phase writes
	localparam int WRITE_BOTH  = 0;
	localparam int WRITE_WIDTH = 1;
	localparam int WRITE_ROWS  = 2;

	typedef struct packed {
		logic [SIDE_W-1:0]    side;
		logic [OUT_ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] col;
	} square_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_wdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata = '0;   // [0] cell_free
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// [9:0] corner_column, [21:10] corner_row, [32:22] square_side
	logic [OUT_DATA_W-1:0]  m_axis_tdata;

	// scorer state
	logic [10:0]           row_width_reg;
	logic [12:0]           row_count_reg;
	logic [SIDE_W-1:0]     below_vals [MAX_W];
	logic [SIDE_W-1:0]     right_v, below_right_v;
	logic [OUT_COL_W-1:0]  col_pos;
	logic [OUT_ROW_W-1:0]  row_pos;
	logic [SIDE_W-1:0]     best_side;
	logic [OUT_COL_W-1:0]  best_col;
	logic [OUT_ROW_W-1:0]  best_row;

	square_t square_q [$];
	int      error_count = 0;
	int      idle_cycles = 0;
	bit      steady = 1'b0;
	int      cur_w, cur_h;

	largest_free_square_finder_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int fit(input int v, input int hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 6);
	endfunction

	task automatic restart_scan();
		right_v       = '0;
		below_right_v = '0;
		col_pos       = OUT_COL_W'(fit(int'(row_width_reg), MAX_W) - 1);
		row_pos       = OUT_ROW_W'(fit(int'(row_count_reg), MAX_H) - 1);
		best_side     = '0;
		best_col      = '0;
		best_row      = '0;
	endtask

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		if (idx == REG_ROW_WIDTH)
			row_width_reg = val[10:0];
		else
			row_count_reg = val;
		restart_scan();
	endtask

	// score one accepted cell; queue the square once the grid is complete
	task automatic score_cell(input bit is_free);
		int                width, rows, col, row;
		bit                bottom, rightmost;
		logic [SIDE_W-1:0] below, score, m;
		square_t           found;
		width = fit(int'(row_width_reg), MAX_W);
		rows  = fit(int'(row_count_reg), MAX_H);
		col   = int'(col_pos);
		row   = int'(row_pos);
		if (col >= width)
			col = width - 1;
		if (row >= rows)
			row = rows - 1;
		bottom    = (row == rows - 1);
		rightmost = (col == width - 1);
		below     = bottom ? '0 : below_vals[col];
		if (!is_free) begin
			score = '0;
		end else if (bottom || rightmost) begin
			score = SIDE_W'(1);
		end else begin
			m = below;
			if (right_v < m)
				m = right_v;
			if (below_right_v < m)
				m = below_right_v;
			score = (m == SIDE_MAX) ? SIDE_MAX : m + 1'b1;
		end
		// equal score: the later cell is higher or further left, so it wins
		if (score != 0 && score >= best_side) begin
			best_side = score;
			best_col  = OUT_COL_W'(col);
			best_row  = OUT_ROW_W'(row);
		end
		below_right_v   = below;
		below_vals[col] = score;
		right_v         = score;
		if (col != 0) begin
			col_pos = OUT_COL_W'(col - 1);
			row_pos = OUT_ROW_W'(row);
			return;
		end
		right_v       = '0;
		below_right_v = '0;
		col_pos       = OUT_COL_W'(width - 1);
		if (row != 0) begin
			row_pos = OUT_ROW_W'(row - 1);
			return;
		end
		found.side = best_side;
		found.row  = best_row;
		found.col  = best_col;
		square_q.push_back(found);
		restart_scan();
	endtask

	task automatic check_square(input logic [OUT_DATA_W-1:0] beat);
		square_t want;
		if (square_q.size() == 0) begin
			note_error($sformatf("result beat %h with nothing expected", beat));
			return;
		end
		want = square_q.pop_front();
		if (beat[9:0] !== want.col || beat[21:10] !== want.row || beat[32:22] !== want.side)
			note_error($sformatf("expected col %0d row %0d side %0d, got col %0d row %0d side %0d",
				want.col, want.row, want.side, beat[9:0], beat[21:10], beat[32:22]));
	endtask

	// sample every handshake at the edge; also the stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				apply_write(cfg_index, cfg_wdata);
			if (m_axis_tvalid && m_axis_tready)
				check_square(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				score_cell(s_axis_tdata[0]);
			if (cfg_we || (m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// result side back-pressure
	initial begin : drain_ready
		int span;
		forever begin
			@(posedge clk);
			span = steady ? 0 : pick_gap();
			if (span == 0) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				repeat (span) @(posedge clk);
				m_axis_tready <= 1'b1;
			end
		end
	end

	// keep tvalid high across back-to-back beats
	task automatic send_cell(input bit is_free);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_W-1){1'b0}}, is_free};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_cells(input int count, input int free_pct);
		for (int i = 0; i < count; i++)
			send_cell($urandom_range(99) < free_pct);
	endtask

	// drop tvalid, wait for every queued square, then let the pipe drain
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (square_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input int width_val, input int rows_val, input int which);
		cfg_we <= 1'b1;
		if (which != WRITE_ROWS) begin
			cfg_index <= REG_ROW_WIDTH;
			cfg_wdata <= width_val[CFG_W-1:0];
			cur_w = fit(width_val & 'h7FF, MAX_W);
			@(posedge clk);
		end
		if (which != WRITE_WIDTH) begin
			cfg_index <= REG_ROW_COUNT;
			cfg_wdata <= rows_val[CFG_W-1:0];
			cur_h = fit(rows_val & 'h1FFF, MAX_H);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// partial grid at the reset sizes, then a write must restart the scan
	task automatic test_write_restarts();
		for (int i = 0; i < 6; i++)
			send_cell(i[0]);
		settle();
		configure(3, 2, WRITE_BOTH);
		send_cells(6, 100);
		send_cells(2, 100);
		settle();
		configure(4, 0, WRITE_WIDTH);
		send_cells(8, 70);
	endtask

	// zero registers act as one; back-to-back single-cell grids
	task automatic test_single_cell();
		settle();
		configure(0, 0, WRITE_BOTH);
		send_cell(1'b1);
		send_cell(1'b0);
		send_cell(1'b1);
	endtask

	task automatic test_no_free_cell();
		settle();
		configure(4, 3, WRITE_BOTH);
		send_cells(12, 0);
	endtask

	// two side-3 squares in the top row: the leftmost must be reported
	task automatic test_tie_break();
		settle();
		configure(4, 3, WRITE_ROWS);
		send_cells(12, 100);
	endtask

	task automatic test_register_limits();
		settle();
		// width above the maximum acts as the maximum; corner at the last column
		configure(2047, 1, WRITE_BOTH);
		for (int c = MAX_W - 1; c >= 0; c--)
			send_cell(c == MAX_W - 1);
		settle();
		// bits above the width register are dropped
		configure(2048 + 3, 2, WRITE_BOTH);
		send_cells(6, 100);
	endtask

	task automatic test_random_grids();
		int  cells, grids, w, h, pct, r, which;
		bit  need_cfg;
		cells    = 0;
		grids    = 0;
		need_cfg = 1'b1;
		while (cells < 250 || grids < 12) begin
			steady = ($urandom_range(4) == 0);
			if (need_cfg || $urandom_range(2) != 0) begin
				r = $urandom_range(19);
				if (r == 0) begin
					w = $urandom_range(64, 17);
					h = $urandom_range(4, 1);
				end else if (r == 1) begin
					w = $urandom_range(4, 1);
					h = $urandom_range(64, 17);
				end else begin
					w = $urandom_range(8, 1);
					h = $urandom_range(8, 1);
				end
				which = $urandom_range(2);
				settle();
				configure(w, h, which);
			end
			need_cfg = 1'b0;
			pct = $urandom_range(100, 40);
			if ($urandom_range(9) == 0) begin
				// abandoned grid; the next write has to restart the scan
				r = $urandom_range(cur_w * cur_h - 1);
				send_cells(r, pct);
				cells += r;
				need_cfg = 1'b1;
			end else begin
				send_cells(cur_w * cur_h, pct);
				cells += cur_w * cur_h;
				grids++;
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		row_width_reg = 11'(ROW_WIDTH_RESET);
		row_count_reg = 13'(ROW_COUNT_RESET);
		cur_w = MAX_W;
		cur_h = MAX_H;
		restart_scan();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_write_restarts();
		test_single_cell();
		test_no_free_cell();
		test_tie_break();
		test_register_limits();
		test_random_grids();
		settle();
		error_count += square_q.size();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
